// File: rtl/dvru_pkg.sv
// Shared types, constants and register codes for the distance-vector route table.
`timescale 1ns / 1ps
package dvru_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int COST_W  = 10;
    localparam int LINK_W  = 10;
    localparam int ID_W    = 5;
    localparam int COUNT_W = 6;
    localparam int STABLE_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [COST_W-1:0]   RESET_COST = COST_W'(999);
    localparam logic [STABLE_W-1:0] STABLE_MAX = {STABLE_W{1'b1}};

    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_ADVERTISE = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUTER_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INFINITY_COST = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ID_W-1:0]   dest;
        logic [LINK_W-1:0] link_to_neighbor;
        logic [ID_W-1:0]   adv_neighbor;
        logic [COST_W-1:0] adv_cost;
        logic [LINK_W-1:0] adv_link;
        logic              adv_local;
    } cmd_t;

    typedef struct packed {
        logic [COST_W-1:0] route_cost;
        logic [LINK_W-1:0] route_link;
        logic              route_local;
        logic              route_reachable;
        logic              updated;
        logic              converged;
    } result_t;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [LINK_W-1:0] link;
        logic              is_local;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/dvru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module dvru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/distance_vector_route_update.sv
// Top level of the distance-vector route table with read-modify-write update.
//
// Usage:
//   Command channel: cmd is taken at a rising edge with start high and busy low.
//   Opcodes load an adjacency entry, apply a neighbor advertisement, or read
//   an entry. Each command gives exactly one result.
//   Result channel: done is high for one cycle with result valid; the result
//   is registered from the execute state and cannot be held off.
//   A new command is not taken while busy. The table sits in one RAM with a
//   registered read; the entry is read in the accept cycle and written back in
//   the following cycle, so busy is high for one cycle per command. A new
//   command may be taken in the cycle that done is shown.
//   Configuration: cfg_valid/cfg_ready write own_id, router_count and
//   infinity_cost by cfg_index; cfg_ready is always high. Write only while idle.
//   Reset: all table entries read as cost 999, link 0, not local (per-entry
//   valid flags, no clearing pass); stable count and registers return to
//   their reset values; no result is pending.
`timescale 1ns / 1ps
module distance_vector_route_update (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  dvru_pkg::cmd_t                        cmd,
    output logic                                  done,
    output dvru_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dvru_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dvru_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    dvru_pkg::cmd_t                     cmd_reg;
    logic [dvru_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [dvru_pkg::STABLE_W-1:0]      stable_reg, stable_next;
    logic [dvru_pkg::ID_W-1:0]          own_id_reg;
    logic [dvru_pkg::COUNT_W-1:0]       router_count_reg;
    logic [dvru_pkg::COST_W-1:0]        inf_reg;
    logic                               done_reg, done_next;
    dvru_pkg::result_t                  result_reg, result_next;

    logic                               accept;
    logic [dvru_pkg::ADDR_W-1:0]        rd_addr;
    logic [dvru_pkg::ADDR_W-1:0]        wr_addr;
    logic [dvru_pkg::ENTRY_W-1:0]       rd_data;
    logic                               wr_en;
    dvru_pkg::entry_t                   old_entry;
    dvru_pkg::entry_t                   new_entry;
    dvru_pkg::entry_t                   shown_entry;
    logic                               in_table;
    logic [dvru_pkg::COST_W:0]          cost_sum;
    logic [dvru_pkg::COST_W-1:0]        cand_cost;
    logic                               take;
    logic                               changed;
    logic                               bump;
    logic                               clear;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;
    assign rd_addr   = dvru_pkg::ADDR_W'(cmd.dest);
    assign wr_addr   = dvru_pkg::ADDR_W'(cmd_reg.dest);
    assign in_table  = (32'(cmd_reg.dest) < 32'(dvru_pkg::TABLE_ENTRIES));

    dvru_ram #(
        .WIDTH (dvru_pkg::ENTRY_W),
        .DEPTH (dvru_pkg::TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (new_entry),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        old_entry = rd_data;
        if (!valid_reg[wr_addr])
        begin
            old_entry.cost     = dvru_pkg::RESET_COST;
            old_entry.link     = '0;
            old_entry.is_local = 1'b0;
        end

        cost_sum  = {1'b0, cmd_reg.adv_cost} + (dvru_pkg::COST_W + 1)'(1);
        cand_cost = (cost_sum > {1'b0, inf_reg}) ? inf_reg
                                                 : cost_sum[dvru_pkg::COST_W-1:0];
        take = (old_entry.cost >= inf_reg) || (old_entry.cost > cand_cost)
            || ((old_entry.link == cmd_reg.link_to_neighbor) && (cand_cost > old_entry.cost));
        changed = (old_entry.cost != cand_cost)
            || (old_entry.link != cmd_reg.link_to_neighbor) || old_entry.is_local;

        new_entry.cost     = cand_cost;
        new_entry.link     = cmd_reg.link_to_neighbor;
        new_entry.is_local = 1'b0;
        wr_en = 1'b0;
        bump  = 1'b0;
        clear = 1'b0;

        if ((state_reg == ST_EXEC) && in_table)
        begin
            priority if (cmd_reg.opcode == dvru_pkg::OP_LOAD)
            begin
                wr_en = 1'b1;
                clear = 1'b1;
                priority if (cmd_reg.dest == own_id_reg)
                begin
                    new_entry.cost     = '0;
                    new_entry.link     = '0;
                    new_entry.is_local = 1'b1;
                end
                else if (cmd_reg.link_to_neighbor != '0)
                begin
                    new_entry.cost     = dvru_pkg::COST_W'(1);
                    new_entry.link     = cmd_reg.link_to_neighbor;
                    new_entry.is_local = 1'b0;
                end
                else
                begin
                    new_entry.cost     = inf_reg;
                    new_entry.link     = '0;
                    new_entry.is_local = 1'b0;
                end
            end
            else if ((cmd_reg.opcode == dvru_pkg::OP_ADVERTISE)
                     && (cmd_reg.link_to_neighbor != '0))
            begin
                priority if ((cmd_reg.adv_cost >= inf_reg) || cmd_reg.adv_local
                             || (cmd_reg.dest == cmd_reg.adv_neighbor))
                begin
                    bump = 1'b1;
                end
                else if (cmd_reg.adv_link != cmd_reg.link_to_neighbor)
                begin
                    if (take && changed)
                    begin
                        wr_en = 1'b1;
                        clear = 1'b1;
                    end
                    else
                    begin
                        bump = 1'b1;
                    end
                end
                else
                begin
                    bump = 1'b0;
                end
            end
            else
            begin
                wr_en = 1'b0;
            end
        end

        stable_next = stable_reg;
        priority if (clear)
        begin
            stable_next = '0;
        end
        else if (bump && (stable_reg != dvru_pkg::STABLE_MAX))
        begin
            stable_next = stable_reg + dvru_pkg::STABLE_W'(1);
        end
        else
        begin
            stable_next = stable_reg;
        end

        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end

        if (!in_table)
        begin
            shown_entry.cost     = inf_reg;
            shown_entry.link     = '0;
            shown_entry.is_local = 1'b0;
        end
        else if (wr_en)
        begin
            shown_entry = new_entry;
        end
        else
        begin
            shown_entry = old_entry;
        end

        result_next.route_cost      = shown_entry.cost;
        result_next.route_link      = shown_entry.link;
        result_next.route_local     = shown_entry.is_local;
        result_next.route_reachable = (shown_entry.cost < inf_reg);
        result_next.updated         = wr_en && (cmd_reg.opcode == dvru_pkg::OP_ADVERTISE);
        result_next.converged       = (stable_next >= {1'b0, router_count_reg});

        done_next = (state_reg == ST_EXEC);

        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_reg        <= '0;
            stable_reg       <= '0;
            done_reg         <= 1'b0;
            own_id_reg       <= dvru_pkg::ID_W'(1);
            router_count_reg <= dvru_pkg::COUNT_W'(1);
            inf_reg          <= dvru_pkg::RESET_COST;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            stable_reg <= stable_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    dvru_pkg::REG_OWN_ID:
                        own_id_reg <= cfg_data[dvru_pkg::ID_W-1:0];
                    dvru_pkg::REG_ROUTER_COUNT:
                        router_count_reg <= cfg_data[dvru_pkg::COUNT_W-1:0];
                    dvru_pkg::REG_INFINITY_COST:
                        inf_reg <= cfg_data[dvru_pkg::COST_W-1:0];
                    default:
                        own_id_reg <= own_id_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_EXEC)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: rtl/dvru_checker.sv
// Port-level checker for the route table, bound to the top level.
`timescale 1ns / 1ps
module dvru_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input dvru_pkg::result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("busy transaction did not complete next cycle");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a transaction in flight");

    a_local_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.route_local) |->
            ((result.route_cost == '0) && (result.route_link == '0) && !result.updated))
        else $error("local entry with nonzero cost or link");

endmodule

bind distance_vector_route_update dvru_checker u_checker (.*);

// File: tb/distance_vector_route_update_tb.sv
// Self-checking testbench for the distance-vector route table update block.
`timescale 1ns / 1ps
module distance_vector_route_update_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    dvru_pkg::cmd_t                  cmd = '0;
    logic                            done;
    dvru_pkg::result_t               result;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dvru_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dvru_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [dvru_pkg::COST_W-1:0]   cost_tbl [dvru_pkg::TABLE_ENTRIES];
    logic [dvru_pkg::LINK_W-1:0]   link_tbl [dvru_pkg::TABLE_ENTRIES];
    logic                          local_tbl [dvru_pkg::TABLE_ENTRIES];
    logic [dvru_pkg::STABLE_W-1:0] stable_cnt;
    logic [dvru_pkg::ID_W-1:0]     own_id_cfg;
    logic [dvru_pkg::COUNT_W-1:0]  router_cnt_cfg;
    logic [dvru_pkg::COST_W-1:0]   inf_cfg;

    logic [dvru_pkg::ID_W-1:0]   nbr_ids [4];
    logic [dvru_pkg::LINK_W-1:0] nbr_links [4];

    dvru_pkg::result_t expected_routes [$];
    int                mismatch_count = 0;
    bit                steady = 1'b0;

    distance_vector_route_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void reset_route_model();
        for (int k = 0; k < dvru_pkg::TABLE_ENTRIES; k++)
        begin
            cost_tbl[k]  = dvru_pkg::RESET_COST;
            link_tbl[k]  = '0;
            local_tbl[k] = 1'b0;
        end
        stable_cnt     = '0;
        own_id_cfg     = dvru_pkg::ID_W'(1);
        router_cnt_cfg = dvru_pkg::COUNT_W'(1);
        inf_cfg        = dvru_pkg::RESET_COST;
    endfunction

    function automatic void count_quiet_advert();
        if (stable_cnt != dvru_pkg::STABLE_MAX)
            stable_cnt = stable_cnt + dvru_pkg::STABLE_W'(1);
    endfunction

    function automatic dvru_pkg::result_t apply_route_cmd(dvru_pkg::cmd_t c);
        dvru_pkg::result_t           r;
        logic [dvru_pkg::COST_W:0]   offer;
        logic [dvru_pkg::COST_W-1:0] old_cost;
        logic [dvru_pkg::LINK_W-1:0] old_link;
        logic                        take;
        r = '0;
        if (c.opcode == dvru_pkg::OP_LOAD)
        begin
            if (c.dest == own_id_cfg)
            begin
                cost_tbl[c.dest]  = '0;
                link_tbl[c.dest]  = '0;
                local_tbl[c.dest] = 1'b1;
            end
            else if (c.link_to_neighbor != '0)
            begin
                cost_tbl[c.dest]  = dvru_pkg::COST_W'(1);
                link_tbl[c.dest]  = c.link_to_neighbor;
                local_tbl[c.dest] = 1'b0;
            end
            else
            begin
                cost_tbl[c.dest]  = inf_cfg;
                link_tbl[c.dest]  = '0;
                local_tbl[c.dest] = 1'b0;
            end
            stable_cnt = '0;
        end
        else if (c.opcode == dvru_pkg::OP_ADVERTISE && c.link_to_neighbor != '0)
        begin
            if (c.adv_cost >= inf_cfg || c.adv_local || c.dest == c.adv_neighbor)
                count_quiet_advert();
            else if (c.adv_link != c.link_to_neighbor)
            begin
                offer = {1'b0, c.adv_cost} + 11'd1;
                if (offer > {1'b0, inf_cfg})
                    offer = {1'b0, inf_cfg};
                old_cost = cost_tbl[c.dest];
                old_link = link_tbl[c.dest];
                take = (old_cost >= inf_cfg) || ({1'b0, old_cost} > offer)
                    || (old_link == c.link_to_neighbor && offer > {1'b0, old_cost});
                if (take && ({1'b0, old_cost} != offer || old_link != c.link_to_neighbor
                    || local_tbl[c.dest]))
                begin
                    cost_tbl[c.dest]  = offer[dvru_pkg::COST_W-1:0];
                    link_tbl[c.dest]  = c.link_to_neighbor;
                    local_tbl[c.dest] = 1'b0;
                    r.updated = 1'b1;
                    stable_cnt = '0;
                end
                else
                    count_quiet_advert();
            end
        end
        r.route_cost      = cost_tbl[c.dest];
        r.route_link      = link_tbl[c.dest];
        r.route_local     = local_tbl[c.dest];
        r.route_reachable = cost_tbl[c.dest] < inf_cfg;
        r.converged       = stable_cnt >= {1'b0, router_cnt_cfg};
        return r;
    endfunction

    function automatic dvru_pkg::cmd_t make_cmd(logic [1:0] op,
                                                logic [dvru_pkg::ID_W-1:0] dest,
                                                logic [dvru_pkg::LINK_W-1:0] lnk,
                                                logic [dvru_pkg::ID_W-1:0] nbr,
                                                logic [dvru_pkg::COST_W-1:0] acost,
                                                logic [dvru_pkg::LINK_W-1:0] alink,
                                                logic alocal);
        dvru_pkg::cmd_t c;
        c.opcode           = op;
        c.dest             = dest;
        c.link_to_neighbor = lnk;
        c.adv_neighbor     = nbr;
        c.adv_cost         = acost;
        c.adv_link         = alink;
        c.adv_local        = alocal;
        return c;
    endfunction

    function automatic dvru_pkg::cmd_t noise_cmd();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(dvru_pkg::cmd_t)-1:0];
    endfunction

    function automatic dvru_pkg::cmd_t pick_route_cmd(bit quiet);
        dvru_pkg::cmd_t c;
        int             k;
        int             roll;
        c = noise_cmd();
        roll = $urandom_range(0, 99);
        if (!quiet && roll < 10)
            return c;
        k = $urandom_range(0, 3);
        c.link_to_neighbor = nbr_links[k];
        c.adv_neighbor     = nbr_ids[k];
        c.adv_local        = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 7) == 0)
            c.adv_cost = dvru_pkg::COST_W'($urandom_range(0, 1023));
        else
            c.adv_cost = dvru_pkg::COST_W'($urandom_range(0, 6));
        case ($urandom_range(0, 3))
            0: c.adv_link = c.link_to_neighbor;
            1: c.adv_link = nbr_links[$urandom_range(0, 3)];
            default: ;
        endcase
        if ($urandom_range(0, 19) == 0)
            c.dest = c.adv_neighbor;
        if (quiet)
        begin
            c.opcode    = (roll < 50) ? dvru_pkg::OP_ADVERTISE
                                      : (roll < 75 ? dvru_pkg::OP_READ : OP_UNUSED);
            c.adv_local = 1'b1;
        end
        else if (roll < 20)
        begin
            c.opcode = dvru_pkg::OP_LOAD;
            if ($urandom_range(0, 2) == 0)
                c.link_to_neighbor = '0;
        end
        else if (roll < 30)
            c.opcode = ($urandom_range(0, 1) == 0) ? dvru_pkg::OP_READ : OP_UNUSED;
        else
            c.opcode = dvru_pkg::OP_ADVERTISE;
        return c;
    endfunction

    task automatic send_route_cmd(input dvru_pkg::cmd_t c);
        while (!steady && $urandom_range(0, 99) < 15)
        begin
            start <= 1'b0;
            cmd   <= noise_cmd();
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        expected_routes.push_back(apply_route_cmd(c));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_routes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_route_reg(input logic [dvru_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [dvru_pkg::CFG_DATA_W-1:0] data);
        while (!steady && $urandom_range(0, 99) < 15)
        begin
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            dvru_pkg::REG_OWN_ID:        own_id_cfg     = data[dvru_pkg::ID_W-1:0];
            dvru_pkg::REG_ROUTER_COUNT:  router_cnt_cfg = data[dvru_pkg::COUNT_W-1:0];
            dvru_pkg::REG_INFINITY_COST: inf_cfg        = data[dvru_pkg::COST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_route_regs(input logic [dvru_pkg::ID_W-1:0] own,
                                  input logic [dvru_pkg::COUNT_W-1:0] count,
                                  input logic [dvru_pkg::COST_W-1:0] inf);
        logic [dvru_pkg::CFG_DATA_W-1:0] data;
        wait_idle();
        data = dvru_pkg::CFG_DATA_W'($urandom);
        data[dvru_pkg::ID_W-1:0] = own;
        write_route_reg(dvru_pkg::REG_OWN_ID, data);
        data = dvru_pkg::CFG_DATA_W'($urandom);
        data[dvru_pkg::COUNT_W-1:0] = count;
        write_route_reg(dvru_pkg::REG_ROUTER_COUNT, data);
        write_route_reg(dvru_pkg::REG_INFINITY_COST, inf);
        cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    always @(negedge clk)
    begin : check_routes
        dvru_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_routes.size() == 0)
                flag_mismatch("unexpected transaction", 0, 1);
            else
            begin
                want = expected_routes.pop_front();
                if (result.route_cost !== want.route_cost)
                    flag_mismatch("route_cost", want.route_cost, result.route_cost);
                if (result.route_link !== want.route_link)
                    flag_mismatch("route_link", want.route_link, result.route_link);
                if (result.route_local !== want.route_local)
                    flag_mismatch("route_local", want.route_local, result.route_local);
                if (result.route_reachable !== want.route_reachable)
                    flag_mismatch("route_reachable", want.route_reachable,
                                  result.route_reachable);
                if (result.updated !== want.updated)
                    flag_mismatch("updated", want.updated, result.updated);
                if (result.converged !== want.converged)
                    flag_mismatch("converged", want.converged, result.converged);
            end
        end
    end

    task automatic test_reset_readback();
        send_route_cmd(make_cmd(dvru_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_READ, 1, 0, 0, 0, 0, 0));
        send_route_cmd(make_cmd(OP_UNUSED, 31, 1023, 31, 1023, 1023, 1));
        send_route_cmd(make_cmd(dvru_pkg::OP_READ, 31, 0, 0, 0, 0, 0));
    endtask

    task automatic test_load_entries();
        send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, 1, 5, 0, 0, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, 5, 1023, 0, 0, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, 6, 0, 0, 0, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, 31, 1, 0, 0, 0, 0));
    endtask

    task automatic test_advert_rules();
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 0, 5, 3, 2, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 1023, 5, 999, 2, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 1023, 5, 3, 2, 1));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 5, 1023, 5, 3, 2, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 1023, 5, 3, 1023, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 1023, 5, 4, 3, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 1023, 5, 4, 3, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 77, 6, 1, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 1023, 5, 5, 3, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 10, 77, 6, 9, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 1, 77, 6, 0, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 12, 77, 6, 998, 0, 0));
    endtask

    task automatic test_register_extremes();
        set_route_regs(31, 0, 1023);
        send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, 31, 0, 0, 0, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 31, 9, 3, 2, 4, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_READ, 0, 0, 0, 0, 0, 0));
        set_route_regs(0, 63, 1);
        send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, 0, 12, 0, 0, 0, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 5, 7, 9, 0, 2, 0));
        set_route_regs(2, 1, 0);
        send_route_cmd(make_cmd(dvru_pkg::OP_ADVERTISE, 7, 3, 4, 0, 1, 0));
        send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, 8, 3, 0, 0, 0, 0));
    endtask

    task automatic run_random_phase(input int n_items, input int n_quiet);
        for (int k = 0; k < 4; k++)
        begin
            nbr_ids[k]   = dvru_pkg::ID_W'($urandom_range(0, 31));
            nbr_links[k] = dvru_pkg::LINK_W'($urandom_range(1, 1023));
            send_route_cmd(make_cmd(dvru_pkg::OP_LOAD, nbr_ids[k], nbr_links[k], 0, 0, 0, 0));
        end
        steady = (n_quiet != 0);
        for (int k = 0; k < n_quiet; k++)
            send_route_cmd(pick_route_cmd(1'b1));
        steady = 1'b0;
        for (int k = 0; k < n_items; k++)
            send_route_cmd(pick_route_cmd(1'b0));
    endtask

    task automatic test_random_traffic();
        set_route_regs(dvru_pkg::ID_W'($urandom_range(0, 31)),
                       dvru_pkg::COUNT_W'($urandom_range(1, 32)), 999);
        run_random_phase(110, 0);
        set_route_regs(dvru_pkg::ID_W'($urandom_range(0, 31)), 63,
                       dvru_pkg::COST_W'($urandom_range(16, 1023)));
        run_random_phase(60, 140);
        set_route_regs(dvru_pkg::ID_W'($urandom_range(0, 31)),
                       dvru_pkg::COUNT_W'($urandom_range(0, 8)),
                       dvru_pkg::COST_W'($urandom_range(2, 20)));
        run_random_phase(110, 0);
    endtask

    initial
    begin
        reset_route_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_readback();
        test_load_entries();
        test_advert_rules();
        test_register_extremes();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
